### hw/rtl/rtc3w_pkg.sv
// ============================================================================
// rtc3w_pkg
// Shared types and constants of the three-wire RTC serial master.
// ============================================================================
`default_nettype none

package rtc3w_pkg;

  // Number of time registers written by set-time and read by read-time.
  localparam int TIME_REGISTERS = 7;
  // Number of configuration registers (one per time register byte).
  localparam int NUM_CFG_REGS   = 7;
  localparam int CFG_IDX_W      = 3;

  // Command codes carried by a request.
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_READ  = 3'd2;
  localparam logic [2:0] CMD_SET   = 3'd3;
  localparam logic [2:0] CMD_GET   = 3'd4;

  // Command bytes and data bytes used by the time sequences.
  localparam logic [7:0] WP_ADDR     = 8'h8E;
  localparam logic [7:0] WP_CLEAR    = 8'h00;
  localparam logic [7:0] WP_SET      = 8'h80;
  localparam logic [7:0] SEC_WR_ADDR = 8'h80;
  localparam logic [7:0] SEC_RD_ADDR = 8'h81;

  // Phase of one byte access.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_ADDR,
    PH_DATA,
    PH_STOP
  } phase_t;

  // Time register bytes as held by the configuration block.
  typedef logic [NUM_CFG_REGS-1:0][7:0] time_regs_t;

  localparam time_regs_t TIME_RESET = {8'h15, 8'h02, 8'h05, 8'h20, 8'h13, 8'h14, 8'h00};

  // One result: pin levels and read status for one tick.
  typedef struct packed {
    logic       enable_pin;
    logic       clock_pin;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic [7:0] read_data;
    logic       read_valid;
    logic [2:0] register_index;
    logic       sequence_last;
  } res_t;

  // Number of byte accesses that a command kind performs.
  function automatic logic [3:0] access_count(input logic [2:0] kind);
    logic [3:0] cnt;
    cnt = 4'd1;
    if (kind == CMD_SET) begin
      cnt = 4'(TIME_REGISTERS + 2);
    end else if (kind == CMD_GET) begin
      cnt = 4'(TIME_REGISTERS);
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/rtc3w_if.sv
// ============================================================================
// rtc3w_if
// Valid/ready channels of the three-wire RTC serial master.
// ============================================================================
`default_nettype none

// Request channel: one tick, optionally carrying a command.
interface rtc3w_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] address;
  logic [7:0] write_data;
  logic       io_in;

  modport source (output valid, command, address, write_data, io_in, input ready);
  modport sink   (input valid, command, address, write_data, io_in, output ready);
endinterface

// Result channel: pin levels and read status of one tick.
interface rtc3w_res_if;
  logic       valid;
  logic       ready;
  logic       enable_pin;
  logic       clock_pin;
  logic       io_out;
  logic       io_drive;
  logic       busy_res;
  logic [7:0] read_data;
  logic       read_valid;
  logic [2:0] register_index;
  logic       sequence_last;

  modport source (output valid, enable_pin, clock_pin, io_out, io_drive, busy_res,
                  read_data, read_valid, register_index, sequence_last, input ready);
  modport sink   (input valid, enable_pin, clock_pin, io_out, io_drive, busy_res,
                  read_data, read_valid, register_index, sequence_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rtc3w_cfg_regs.sv
// ============================================================================
// rtc3w_cfg_regs
// Time register bytes written through the configuration port.
// ============================================================================
`default_nettype none

module rtc3w_cfg_regs
  import rtc3w_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  output time_regs_t                time_regs
);

  time_regs_t regs_r;

  // Writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= TIME_RESET;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG_REGS))) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  assign time_regs = regs_r;

endmodule

`default_nettype wire

### hw/rtl/rtc3w_core.sv
// ============================================================================
// rtc3w_core
// Access sequencer: tracks phase, bit and step, and forms one result per tick.
// ============================================================================
`default_nettype none

module rtc3w_core
  import rtc3w_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step_en,
  input  wire logic [2:0] command,
  input  wire logic [7:0] address,
  input  wire logic [7:0] write_data,
  input  wire logic       io_in,
  input  wire time_regs_t time_regs,
  output res_t            res
);

  phase_t     phase_r, phase_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [3:0] step_r, step_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic       half_r, half_nxt;
  logic [7:0] shift_in_r, shift_in_nxt;
  logic [7:0] single_addr_r, single_addr_nxt;
  logic [7:0] single_data_r, single_data_nxt;

  logic       start;
  phase_t     cur_phase;
  logic [2:0] kind_eff;
  logic       reads;
  logic [3:0] step_inc;
  logic       seq_done;
  logic [3:0] tidx;
  logic [7:0] treg;
  logic [7:0] addr_byte;
  logic [7:0] data_byte;
  logic       tx_bit;

  // A command starts only while idle; unknown codes are plain ticks.
  assign start = (phase_r == PH_IDLE) &&
                 (command == CMD_WRITE || command == CMD_READ ||
                  command == CMD_SET   || command == CMD_GET);
  assign cur_phase = start ? PH_START : phase_r;
  assign kind_eff  = start ? command : kind_r;
  assign reads     = (kind_eff == CMD_READ) || (kind_eff == CMD_GET);
  assign step_inc  = step_r + 4'd1;
  assign seq_done  = !(step_inc < access_count(kind_r));

  // Time register for the current set-time step; registers past the list read 0.
  assign tidx = step_r - 4'd1;
  assign treg = (tidx < 4'(NUM_CFG_REGS)) ? time_regs[tidx[2:0]] : 8'h00;

  // Command byte and data byte of the current access.
  always_comb begin
    addr_byte = single_addr_r;
    data_byte = single_data_r;
    if (kind_r == CMD_SET) begin
      if (step_r == 4'd0) begin
        addr_byte = WP_ADDR;
        data_byte = WP_CLEAR;
      end else if (step_r > 4'(TIME_REGISTERS)) begin
        addr_byte = WP_ADDR;
        data_byte = WP_SET;
      end else begin
        addr_byte = SEC_WR_ADDR + 8'({tidx, 1'b0});
        data_byte = treg;
      end
    end else if (kind_r == CMD_GET) begin
      addr_byte = SEC_RD_ADDR + 8'({step_r, 1'b0});
      data_byte = 8'h00;
    end
  end

  assign tx_bit = (phase_r == PH_ADDR) ? addr_byte[bit_r] : data_byte[bit_r];

  // Next state.
  always_comb begin
    phase_nxt       = phase_r;
    kind_nxt        = kind_r;
    step_nxt        = step_r;
    bit_nxt         = bit_r;
    half_nxt        = half_r;
    shift_in_nxt    = shift_in_r;
    single_addr_nxt = single_addr_r;
    single_data_nxt = single_data_r;
    if (start) begin
      kind_nxt        = command;
      single_addr_nxt = address;
      single_data_nxt = write_data;
      step_nxt        = 4'd0;
    end
    unique case (cur_phase)
      PH_IDLE: begin
        phase_nxt = PH_IDLE;
      end
      PH_START: begin
        phase_nxt = PH_ADDR;
        bit_nxt   = 3'd0;
        half_nxt  = 1'b0;
      end
      PH_ADDR, PH_DATA: begin
        if (cur_phase == PH_DATA && reads && !half_r) begin
          shift_in_nxt = {io_in, shift_in_r[7:1]};
        end
        if (!half_r) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          bit_nxt  = bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            phase_nxt = (cur_phase == PH_ADDR) ? PH_DATA : PH_STOP;
          end
        end
      end
      PH_STOP: begin
        if (seq_done) begin
          phase_nxt = PH_IDLE;
          step_nxt  = 4'd0;
        end else begin
          phase_nxt = PH_START;
          step_nxt  = step_inc;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Result of the current tick.
  always_comb begin
    res          = '0;
    res.busy_res = (cur_phase != PH_IDLE);
    unique case (cur_phase)
      PH_ADDR, PH_DATA: begin
        res.enable_pin = 1'b1;
        res.clock_pin  = half_r;
        res.io_drive   = !(cur_phase == PH_DATA && reads);
        res.io_out     = res.io_drive & tx_bit;
      end
      PH_STOP: begin
        res.sequence_last = seq_done;
        if (reads) begin
          res.read_valid     = 1'b1;
          res.read_data      = shift_in_r;
          res.register_index = (kind_r == CMD_GET) ? step_r[2:0] : 3'd0;
        end
      end
      default: begin
        res.busy_res = (cur_phase != PH_IDLE);
      end
    endcase
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      kind_r        <= CMD_TICK;
      step_r        <= 4'd0;
      bit_r         <= 3'd0;
      half_r        <= 1'b0;
      shift_in_r    <= 8'h00;
      single_addr_r <= 8'h00;
      single_data_r <= 8'h00;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      kind_r        <= kind_nxt;
      step_r        <= step_nxt;
      bit_r         <= bit_nxt;
      half_r        <= half_nxt;
      shift_in_r    <= shift_in_nxt;
      single_addr_r <= single_addr_nxt;
      single_data_r <= single_data_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rtc_three_wire_serial_master.sv
// ============================================================================
// rtc_three_wire_serial_master
// Three-wire serial master for a real-time-clock chip, one tick per request.
// ============================================================================
// Usage:
//   Each request on in_ch is one half period of the serial clock. Its command
//   field may start a single write, a single read, a set-time sequence or a
//   read-time sequence; commands that arrive while an access runs are ignored.
//   Every request yields exactly one result on out_ch with the enable, clock
//   and data pin levels for that tick, plus busy, read data and last flags.
//   Each byte access takes 34 ticks: start, 16 address ticks, 16 data ticks,
//   stop. Set-time runs nine accesses, read-time seven.
//   The result is registered and valid the cycle after the request is
//   accepted. Throughput is one request per cycle while the receiver takes
//   results, set by the single state update of the access sequencer.
//   When the receiver stalls, the held result stays on out_ch and a new
//   request is accepted in the same cycle the held one is taken.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, empties the
//   result register and loads the default time register bytes.
//   The cfg_ port writes time register bytes; write only while idle.
// ============================================================================
`default_nettype none

module rtc_three_wire_serial_master
  import rtc3w_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rtc3w_req_if.sink                 in_ch,
  rtc3w_res_if.source               out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  time_regs_t time_regs;
  res_t       core_res;
  res_t       res_r;
  logic       out_valid_r;
  logic       in_fire;

  // Time register bytes.
  rtc3w_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .time_regs (time_regs)
  );

  // Access sequencer.
  rtc3w_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_fire),
    .command    (in_ch.command),
    .address    (in_ch.address),
    .write_data (in_ch.write_data),
    .io_in      (in_ch.io_in),
    .time_regs  (time_regs),
    .res        (core_res)
  );

  // Accept when the result register is empty or is being emptied.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.enable_pin     = res_r.enable_pin;
  assign out_ch.clock_pin      = res_r.clock_pin;
  assign out_ch.io_out         = res_r.io_out;
  assign out_ch.io_drive       = res_r.io_drive;
  assign out_ch.busy_res       = res_r.busy_res;
  assign out_ch.read_data      = res_r.read_data;
  assign out_ch.read_valid     = res_r.read_valid;
  assign out_ch.register_index = res_r.register_index;
  assign out_ch.sequence_last  = res_r.sequence_last;

  // The serial clock only rises while enable is high.
  a_clk_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.clock_pin) |-> res_r.enable_pin)
    else $error("clock pin high with enable low");

  // Read bytes are reported on a stop tick of a running command.
  a_read_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.read_valid) |-> (res_r.busy_res && !res_r.enable_pin))
    else $error("read byte outside a stop tick");

  // A released data pin carries no level.
  a_released_io_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.io_drive) |-> !res_r.io_out)
    else $error("io level driven while released");

  // After the final tick of a command, the next tick is idle unless it starts one.
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && core_res.sequence_last) ##1 (in_fire && in_ch.command == CMD_TICK)
      |-> !core_res.busy_res)
    else $error("sequencer busy after the final tick");

endmodule

`default_nettype wire

### tb/tb_rtc_three_wire_serial_master.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_rtc_three_wire_serial_master
// Self-checking testbench of the three-wire RTC serial master.
// ----------------------------------------------------------------------------
// Every tick request is mirrored in a tick-accurate model of the access
// sequencer inside this bench. The expected pin levels of each tick are
// queued and compared field by field with the result channel. A short table
// of commands runs first, then randomized command streams under several
// time register settings, with random gaps on both channels, a long
// receiver hold-off and a full drain in the middle of the run.
// ============================================================================

module tb_rtc_three_wire_serial_master;
  import rtc3w_pkg::*;

  // Command codes outside the defined set; the block treats them as ticks.
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Configuration index past the last time register; writes are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(NUM_CFG_REGS);

  // Ticks per byte access: start, 16 address, 16 data, stop.
  localparam int ACCESS_TICKS = 34;

  // Result of an idle tick, and of the first tick of any access.
  localparam res_t EXP_IDLE  = '0;
  localparam res_t EXP_START = '{enable_pin: 1'b0, clock_pin: 1'b0, io_out: 1'b0,
                                 io_drive: 1'b0, busy_res: 1'b1, read_data: 8'h00,
                                 read_valid: 1'b0, register_index: 3'd0,
                                 sequence_last: 1'b0};

  // One row of the directed command table.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] addr;
    logic [7:0] wdata;
    logic [7:0] io_pat;
    logic [2:0] noise_cmd;
    logic       noisy;
    logic       typed;
    res_t       exp_first;
  } cmd_row_t;

  localparam int NUM_ROWS = 15;

  cmd_row_t cmd_table [NUM_ROWS] = '{
    '{CMD_TICK,    8'h00, 8'h00, 8'h00, CMD_TICK,  1'b0, 1'b1, EXP_IDLE},
    '{CMD_SPARE_5, 8'hFF, 8'hFF, 8'hFF, CMD_TICK,  1'b0, 1'b1, EXP_IDLE},
    '{CMD_SPARE_6, 8'hFF, 8'h00, 8'hFF, CMD_TICK,  1'b0, 1'b1, EXP_IDLE},
    '{CMD_SPARE_7, 8'h00, 8'hFF, 8'h00, CMD_TICK,  1'b0, 1'b1, EXP_IDLE},
    '{CMD_WRITE,   8'h00, 8'h00, 8'h00, CMD_TICK,  1'b0, 1'b1, EXP_START},
    '{CMD_WRITE,   8'hFF, 8'hFF, 8'hFF, CMD_TICK,  1'b0, 1'b1, EXP_START},
    '{CMD_WRITE,   8'hA5, 8'h5A, 8'h0F, CMD_TICK,  1'b0, 1'b0, EXP_IDLE},
    '{CMD_READ,    8'h81, 8'h00, 8'h00, CMD_TICK,  1'b0, 1'b1, EXP_START},
    '{CMD_READ,    8'hFF, 8'hFF, 8'hFF, CMD_TICK,  1'b0, 1'b0, EXP_IDLE},
    '{CMD_READ,    8'h00, 8'h00, 8'hA5, CMD_TICK,  1'b0, 1'b0, EXP_IDLE},
    '{CMD_WRITE,   8'h3C, 8'hC3, 8'h00, CMD_READ,  1'b1, 1'b0, EXP_IDLE},
    '{CMD_READ,    8'h5A, 8'h00, 8'h96, CMD_SET,   1'b1, 1'b0, EXP_IDLE},
    '{CMD_SET,     8'h00, 8'h00, 8'h00, CMD_GET,   1'b1, 1'b1, EXP_START},
    '{CMD_READ,    8'h01, 8'h80, 8'h7E, CMD_TICK,  1'b0, 1'b0, EXP_IDLE},
    '{CMD_TICK,    8'hFF, 8'hFF, 8'hFF, CMD_TICK,  1'b0, 1'b1, EXP_IDLE}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  rtc3w_req_if req_ch ();
  rtc3w_res_if res_ch ();

  rtc_three_wire_serial_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the access sequencer.
  phase_t     seq_phase;
  logic [3:0] bits_done;
  logic       high_half;
  logic [7:0] tx_byte;
  logic [7:0] rx_byte;
  logic [7:0] data_byte;
  logic [2:0] seq_kind;
  logic [3:0] access_idx;
  logic [7:0] single_addr;
  logic [7:0] single_data;
  time_regs_t time_bytes;

  // Expected pin levels of every accepted tick, oldest first.
  res_t tick_results_q [$];

  int ticks_sent;
  int mismatches;
  int reports;
  int gap_max;
  int stall_max;
  bit long_hold;

  // Load address and data of the access selected by access_idx.
  function automatic void load_access();
    logic [7:0] a;
    logic [7:0] d;
    int         reg_idx;
    d = 8'h00;
    reg_idx = int'(access_idx) - 1;
    if (seq_kind == CMD_SET) begin
      if (access_idx == 4'd0) begin
        a = WP_ADDR;
        d = WP_CLEAR;
      end else if (int'(access_idx) > TIME_REGISTERS) begin
        a = WP_ADDR;
        d = WP_SET;
      end else begin
        a = SEC_WR_ADDR + 8'(2 * reg_idx);
        d = (reg_idx < NUM_CFG_REGS) ? time_bytes[reg_idx] : 8'h00;
      end
    end else if (seq_kind == CMD_GET) begin
      a = SEC_RD_ADDR + 8'(2 * int'(access_idx));
    end else begin
      a = single_addr;
      d = single_data;
    end
    tx_byte   = a;
    data_byte = d;
    rx_byte   = 8'h00;
    bits_done = 4'd0;
    high_half = 1'b0;
    seq_phase = PH_START;
  endfunction

  // Advance the sequencer by one tick and return the pin levels it shows.
  function automatic res_t predict_tick(input logic [2:0] cmd, input logic [7:0] addr,
                                        input logic [7:0] wdata, input logic io);
    res_t       r;
    int         n_accesses;
    logic       reading;
    r = '0;
    if (seq_phase == PH_IDLE && cmd >= CMD_WRITE && cmd <= CMD_GET) begin
      seq_kind    = cmd;
      access_idx  = 4'd0;
      single_addr = addr;
      single_data = wdata;
      load_access();
    end
    reading = (seq_kind == CMD_READ) || (seq_kind == CMD_GET);
    if (seq_phase != PH_IDLE) r.busy_res = 1'b1;
    case (seq_phase)
      PH_START: begin
        seq_phase = PH_ADDR;
      end
      PH_ADDR, PH_DATA: begin
        r.enable_pin = 1'b1;
        // Reads sample the pin while the clock is still low.
        if (seq_phase == PH_DATA && reading) begin
          if (!high_half) rx_byte = {io, rx_byte[7:1]};
        end else begin
          r.io_drive = 1'b1;
          r.io_out   = tx_byte[0];
        end
        if (!high_half) begin
          high_half = 1'b1;
        end else begin
          r.clock_pin = 1'b1;
          high_half   = 1'b0;
          tx_byte     = tx_byte >> 1;
          bits_done   = bits_done + 4'd1;
          if (bits_done >= 4'd8) begin
            bits_done = 4'd0;
            if (seq_phase == PH_ADDR) begin
              seq_phase = PH_DATA;
              tx_byte   = data_byte;
            end else begin
              seq_phase = PH_STOP;
            end
          end
        end
      end
      PH_STOP: begin
        if (reading) begin
          r.read_valid     = 1'b1;
          r.read_data      = rx_byte;
          r.register_index = (seq_kind == CMD_GET) ? access_idx[2:0] : 3'd0;
        end
        access_idx = access_idx + 4'd1;
        n_accesses = 1;
        if (seq_kind == CMD_SET) n_accesses = TIME_REGISTERS + 2;
        else if (seq_kind == CMD_GET) n_accesses = TIME_REGISTERS;
        if (int'(access_idx) < n_accesses) begin
          load_access();
        end else begin
          r.sequence_last = 1'b1;
          seq_phase       = PH_IDLE;
          access_idx      = 4'd0;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
      end
    endcase
    return r;
  endfunction

  // Offer one tick request after a random gap and wait for its acceptance.
  task automatic send_tick(input logic [2:0] cmd, input logic [7:0] addr,
                           input logic [7:0] wdata, input logic io,
                           input logic typed, input res_t typed_res);
    int   gap;
    res_t r;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.command    <= cmd;
    req_ch.address    <= addr;
    req_ch.write_data <= wdata;
    req_ch.io_in      <= io;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    r = predict_tick(cmd, addr, wdata, io);
    tick_results_q.push_back(typed ? typed_res : r);
    ticks_sent++;
  endtask

  // Issue a command and keep ticking until the sequencer is idle again.
  // The io pattern is laid out so that bit i is sampled as data bit i.
  task automatic run_command(input logic [2:0] cmd, input logic [7:0] addr,
                             input logic [7:0] wdata, input logic [7:0] io_pat,
                             input int noise_pct, input logic [2:0] noise_cmd,
                             input logic typed, input res_t exp_first);
    int         t;
    logic [2:0] c;
    send_tick(cmd, addr, wdata, io_pat[7], typed, exp_first);
    t = 1;
    while (seq_phase != PH_IDLE) begin
      c = CMD_TICK;
      if ($urandom_range(0, 99) < noise_pct) begin
        c = (noise_cmd == CMD_TICK) ? 3'($urandom_range(0, 7)) : noise_cmd;
      end
      send_tick(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                io_pat[3'((((t % ACCESS_TICKS) + 15) >> 1) & 7)], 1'b0, EXP_IDLE);
      t++;
    end
  endtask

  // Stop offering requests until every expected result has come back.
  task automatic await_results();
    req_ch.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  // Write all time registers while the block is idle.
  task automatic write_time_regs(input time_regs_t vals, input logic touch_spare);
    await_results();
    repeat (4) @(posedge clk);
    for (int i = 0; i < NUM_CFG_REGS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
      time_bytes[i] = vals[i];
    end
    // The index past the register file must not disturb anything.
    if (touch_spare) begin
      cfg_index <= CFG_SPARE_INDEX;
      cfg_wdata <= 8'($urandom_range(0, 255));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random command stream; mostly complete commands with random content.
  task automatic random_phase(input int n_items, input int pause_after);
    int         target;
    int         pause_mark;
    int         sel;
    int         pct;
    logic [2:0] c;
    target     = ticks_sent + n_items;
    pause_mark = (pause_after > 0) ? ticks_sent + pause_after : 0;
    run_command(CMD_SET, 8'h00, 8'h00, 8'($urandom_range(0, 255)), 0, CMD_TICK,
                1'b0, EXP_IDLE);
    while (ticks_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 90) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) c = CMD_WRITE;
        else if (sel < 70) c = CMD_READ;
        else if (sel < 80) c = CMD_SET;
        else c = CMD_GET;
        // About half the commands run clean; the rest take stray commands, a few many.
        pct = $urandom_range(0, 1) ? 0 : $urandom_range(1, 10);
        if ($urandom_range(0, 9) == 0) pct = $urandom_range(50, 100);
        run_command(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), pct, CMD_TICK, 1'b0, EXP_IDLE);
      end else begin
        // Idle ticks, including the undefined command codes.
        repeat ($urandom_range(1, 5)) begin
          sel = $urandom_range(0, 3);
          c = (sel == 0) ? CMD_TICK : 3'(4 + sel);
          send_tick(c, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'b0, EXP_IDLE);
        end
      end
      if (pause_mark > 0 && ticks_sent >= pause_mark) begin
        pause_mark = 0;
        await_results();
      end
    end
  endtask

  // Field-by-field check of one result.
  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      // Further mismatches are counted but not printed.
      if (reports < 100) begin
        reports++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, exp_v,
                 act_v);
      end
    end
  endtask

  // Result receiver: random stalls, one long hold-off on request.
  initial begin : result_sink
    int   stall;
    res_t e;
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = long_hold ? 300 : $urandom_range(0, stall_max);
      long_hold = 1'b0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (res_ch.valid !== 1'b1) @(posedge clk);
      if (tick_results_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no request pending", $time);
      end else begin
        e = tick_results_q.pop_front();
        compare_field("enable_pin", int'(e.enable_pin), int'(res_ch.enable_pin));
        compare_field("clock_pin", int'(e.clock_pin), int'(res_ch.clock_pin));
        compare_field("io_out", int'(e.io_out), int'(res_ch.io_out));
        compare_field("io_drive", int'(e.io_drive), int'(res_ch.io_drive));
        compare_field("busy_res", int'(e.busy_res), int'(res_ch.busy_res));
        compare_field("read_data", int'(e.read_data), int'(res_ch.read_data));
        compare_field("read_valid", int'(e.read_valid), int'(res_ch.read_valid));
        compare_field("register_index", int'(e.register_index),
                      int'(res_ch.register_index));
        compare_field("sequence_last", int'(e.sequence_last),
                      int'(res_ch.sequence_last));
      end
    end
  end

  // Stimulus: reset, command table, then randomized phases.
  initial begin : stimulus
    time_regs_t vals;
    ticks_sent = 0;
    mismatches = 0;
    reports    = 0;
    long_hold  = 1'b0;
    gap_max    = 17;
    stall_max  = 17;
    seq_phase   = PH_IDLE;
    bits_done   = 4'd0;
    high_half   = 1'b0;
    tx_byte     = 8'h00;
    rx_byte     = 8'h00;
    data_byte   = 8'h00;
    seq_kind    = 3'd0;
    access_idx  = 4'd0;
    single_addr = 8'h00;
    single_data = 8'h00;
    time_bytes  = TIME_RESET;
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.command    <= CMD_TICK;
    req_ch.address    <= 8'h00;
    req_ch.write_data <= 8'h00;
    req_ch.io_in      <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= 8'h00;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed commands with the reset time register bytes.
    for (int i = 0; i < NUM_ROWS; i++) begin
      run_command(cmd_table[i].cmd, cmd_table[i].addr, cmd_table[i].wdata,
                  cmd_table[i].io_pat, cmd_table[i].noisy ? 100 : 0,
                  cmd_table[i].noise_cmd, cmd_table[i].typed, cmd_table[i].exp_first);
    end

    // All bytes zero, random gaps on both sides.
    write_time_regs('0, 1'b0);
    random_phase(320, 0);

    // All bytes ones, back-to-back traffic.
    gap_max   = 0;
    stall_max = 0;
    write_time_regs('1, 1'b1);
    random_phase(320, 0);

    // Random bytes with a long receiver hold-off and a full drain midway.
    gap_max   = 17;
    stall_max = 17;
    for (int i = 0; i < NUM_CFG_REGS; i++) vals[i] = 8'($urandom_range(0, 255));
    write_time_regs(vals, 1'b1);
    long_hold = 1'b1;
    random_phase(320, 200);

    await_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hw/rtl/rtc3w_pkg.sv
hw/rtl/rtc3w_if.sv
hw/rtl/rtc3w_cfg_regs.sv
hw/rtl/rtc3w_core.sv
hw/rtl/rtc_three_wire_serial_master.sv
tb/tb_rtc_three_wire_serial_master.sv
